FILE: rtl/pid_position_delta_controller_core_macros.svh
// Assertion macros shared by the controller RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks away.
`ifndef PID_POSITION_DELTA_CONTROLLER_CORE_MACROS_SVH
`define PID_POSITION_DELTA_CONTROLLER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define PPDC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ppdc: same-cycle check failed");
// next-cycle implication
`define PPDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ppdc: next-cycle check failed");
`else
`define PPDC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PPDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/ppdc_pkg.sv
// Types and constants for the PID position/delta controller.
// No dependencies; used by the controller, datapath and top level.
package ppdc_pkg;

	// derivative low-pass coefficient, Q0.16, and its complement
	localparam int D_FILTER_COEF   = 13107;
	localparam int INTEG_SEP_LIMIT = 32767;
	localparam logic signed [31:0] FILT_C  = 32'(D_FILTER_COEF);
	localparam logic signed [31:0] FILT_C1 = 32'(65536 - D_FILTER_COEF);
	localparam logic [16:0] SEP_LIM = 17'(INTEG_SEP_LIMIT);

	localparam logic MODE_POS   = 1'b0;
	localparam logic MODE_DELTA = 1'b1;
	localparam logic CMD_STEP   = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	typedef enum logic [2:0] {
		REG_MODE     = 3'd0,
		REG_KP       = 3'd1,
		REG_KI       = 3'd2,
		REG_KD       = 3'd3,
		REG_KF       = 3'd4,
		REG_MAX_OUT  = 3'd5,
		REG_INT_LIM  = 3'd6,
		REG_DEADBAND = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic               cmd;
		logic signed [15:0] setpoint;
		logic signed [15:0] feedback;
	} item_t;

	typedef struct packed {
		logic signed [15:0] drive;
		logic               at_limit;
	} result_t;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] kp;
		logic signed [31:0] ki;
		logic signed [31:0] kd;
		logic signed [31:0] kf;
		logic [14:0]        max_out;
		logic [14:0]        int_lim;
		logic [14:0]        deadband;
	} cfg_t;

	// products issued to the shared multiplier
	typedef enum logic [3:0] {
		OP_NONE,
		OP_P,   // kp * e (or e - e1)
		OP_I,   // ki * (e + e1) (or e)
		OP_DH,  // (1-c) * d[35:16]
		OP_DC,  // c * diff
		OP_DL,  // (1-c) * d[15:0]
		OP_F,   // kf * setpoint
		OP_KH,  // kd * dnew[35:16]
		OP_KL   // kd * dnew[15:0]
	} mul_op_t;

	typedef struct packed {
		logic    load;
		logic    err;
		mul_op_t mul_op;
		logic    clamp_int;
		logic    add_int;
		logic    clamp_out;
		logic    commit;
		logic    clear;
	} dp_cmd_t;

	typedef struct packed {
		logic out_stall;
	} dp_status_t;

endpackage

FILE: rtl/ppdc_ctrl.sv
// Sequencer for the PID controller: steps the shared multiplier schedule.
// Depends on ppdc_pkg and the assertion macro header.
`include "pid_position_delta_controller_core_macros.svh"
module ppdc_ctrl import ppdc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       item_cmd,
	output logic       item_ready,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_ERR, ST_P, ST_I, ST_DH, ST_DC, ST_DL, ST_F,
		ST_KH, ST_KL, ST_KW, ST_CLAMP, ST_FIN, ST_CLR
	} state_t;

	state_t state_q;

	assign item_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= (item_cmd == CMD_CLEAR) ? ST_CLR : ST_ERR;
					end
				end
				ST_ERR:   state_q <= ST_P;
				ST_P:     state_q <= ST_I;
				ST_I:     state_q <= ST_DH;
				ST_DH:    state_q <= ST_DC;
				ST_DC:    state_q <= ST_DL;
				ST_DL:    state_q <= ST_F;
				ST_F:     state_q <= ST_KH;
				ST_KH:    state_q <= ST_KL;
				ST_KL:    state_q <= ST_KW;
				ST_KW:    state_q <= ST_CLAMP;
				ST_CLAMP: state_q <= ST_FIN;
				ST_FIN, ST_CLR: begin
					if (!status.out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.mul_op = OP_NONE;
		unique case (state_q)
			ST_IDLE:  cmd.load = item_valid;
			ST_ERR:   cmd.err = 1'b1;
			ST_P:     cmd.mul_op = OP_P;
			ST_I:     cmd.mul_op = OP_I;
			ST_DH:    cmd.mul_op = OP_DH;
			ST_DC: begin
				cmd.mul_op    = OP_DC;
				cmd.clamp_int = 1'b1;
			end
			ST_DL: begin
				cmd.mul_op  = OP_DL;
				cmd.add_int = 1'b1;
			end
			ST_F:     cmd.mul_op = OP_F;
			ST_KH:    cmd.mul_op = OP_KH;
			ST_KL:    cmd.mul_op = OP_KL;
			ST_KW:    cmd.mul_op = OP_NONE;
			ST_CLAMP: cmd.clamp_out = 1'b1;
			ST_FIN:   cmd.commit = !status.out_stall;
			ST_CLR:   cmd.clear = !status.out_stall;
			default:  cmd.mul_op = OP_NONE;
		endcase
	end

	`PPDC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item_valid && item_ready, !item_ready)
	`PPDC_ASSERT_IMPL(a_idle_no_mul, clk, arst_n, item_ready, cmd.mul_op == OP_NONE)
	`PPDC_ASSERT_NEXT(a_commit_once, clk, arst_n, cmd.commit || cmd.clear, item_ready)

endmodule

FILE: rtl/ppdc_datapath.sv
// Datapath for the PID controller: error stage, shared 32x20 multiplier,
// accumulators, clamps, controller state and result register.
// Depends on ppdc_pkg and the assertion macro header.
`include "pid_position_delta_controller_core_macros.svh"
module ppdc_datapath import ppdc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  item_t      item,
	input  dp_cmd_t    cmd,
	input  logic       result_ready,
	output logic       result_valid,
	output result_t    result,
	output dp_status_t status
);

	// latched operands and error
	logic signed [15:0] sp_q, fb_q;
	logic signed [16:0] e_q;
	logic               int_en_q;

	// controller state
	logic signed [16:0] el_q, ebl_q;
	logic signed [35:0] deriv_q;
	logic signed [47:0] integ_q;
	logic signed [31:0] out_acc_q;

	// working registers
	mul_op_t            op_s1;
	logic signed [51:0] prod_s1;
	logic signed [55:0] acc_q;
	logic signed [49:0] integ_tmp_q;
	logic signed [37:0] dtmp_q;
	logic signed [31:0] oacc_tmp_q;
	logic               hit_q;
	logic               res_valid_q;
	result_t            res_q;

	// error stage
	logic signed [16:0] raw_err, err_n;
	logic [16:0]        err_mag;
	logic               in_dead, blocked, sep_ok;
	logic signed [32:0] lim_out, out_acc_x;

	always_comb begin
		raw_err   = {sp_q[15], sp_q} - {fb_q[15], fb_q};
		err_mag   = raw_err[16] ? 17'(-raw_err) : 17'(raw_err);
		in_dead   = (err_mag < {2'b00, cfg.deadband});
		err_n     = in_dead ? 17'sd0 : raw_err;
		sep_ok    = in_dead || (err_mag < SEP_LIM);
		lim_out   = $signed({2'b00, cfg.max_out, 16'h0000});
		out_acc_x = {out_acc_q[31], out_acc_q};
		blocked   = ((out_acc_x >= lim_out) && (err_n > 17'sd0)) ||
			((out_acc_x <= -lim_out) && (err_n < 17'sd0));
	end

	// multiplier operand select
	logic signed [17:0] e_sum, e_dif;
	logic signed [18:0] diff_d;
	logic signed [31:0] mul_a;
	logic signed [19:0] mul_b;

	always_comb begin
		e_sum  = {e_q[16], e_q} + {el_q[16], el_q};
		e_dif  = {e_q[16], e_q} - {el_q[16], el_q};
		// delta mode filters the second difference
		diff_d = (cfg.mode == MODE_DELTA) ?
			({{2{e_q[16]}}, e_q} - {el_q[16], el_q, 1'b0} + {{2{ebl_q[16]}}, ebl_q}) :
			{e_dif[17], e_dif};
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_op)
			OP_P: begin
				mul_a = cfg.kp;
				mul_b = (cfg.mode == MODE_DELTA) ? {{2{e_dif[17]}}, e_dif} :
					{{3{e_q[16]}}, e_q};
			end
			OP_I: begin
				mul_a = cfg.ki;
				mul_b = (cfg.mode == MODE_DELTA) ? {{3{e_q[16]}}, e_q} :
					{{2{e_sum[17]}}, e_sum};
			end
			OP_DH: begin
				mul_a = FILT_C1;
				mul_b = deriv_q[35:16];
			end
			OP_DC: begin
				mul_a = FILT_C;
				mul_b = {diff_d[18], diff_d};
			end
			OP_DL: begin
				mul_a = FILT_C1;
				mul_b = {4'b0000, deriv_q[15:0]};
			end
			OP_F: begin
				mul_a = cfg.kf;
				mul_b = {{4{sp_q[15]}}, sp_q};
			end
			OP_KH: begin
				mul_a = cfg.kd;
				mul_b = dtmp_q[35:16];
			end
			OP_KL: begin
				mul_a = cfg.kd;
				mul_b = {4'b0000, dtmp_q[15:0]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// accumulate stage, driven by the op that produced prod_s1
	logic signed [55:0] prod_x, prod_sh16, prod_sh1;
	logic signed [55:0] acc_base, op_term, aux_term, acc_d;
	logic signed [49:0] ilim, integ_base;
	logic signed [55:0] lim56;

	always_comb begin
		prod_x    = {{4{prod_s1[51]}}, prod_s1};
		prod_sh16 = prod_x >>> 16;
		prod_sh1  = prod_x >>> 1;
		acc_base  = acc_q;
		op_term   = '0;
		case (op_s1)
			OP_P: begin
				acc_base = (cfg.mode == MODE_DELTA) ? {{24{out_acc_q[31]}}, out_acc_q} :
					56'sd0;
				op_term  = prod_x;
			end
			OP_I:    op_term = (cfg.mode == MODE_DELTA) ? prod_x : 56'sd0;
			OP_F:    op_term = (cfg.mode == MODE_POS) ? prod_x : 56'sd0;
			OP_KH:   op_term = prod_x;
			OP_KL:   op_term = prod_sh16;
			default: op_term = '0;
		endcase
		aux_term = (cmd.add_int && cfg.mode == MODE_POS) ?
			{{6{integ_tmp_q[49]}}, integ_tmp_q} : 56'sd0;
		acc_d      = acc_base + op_term + aux_term;
		integ_base = {{2{integ_q[47]}}, integ_q};
		ilim       = $signed({19'd0, cfg.int_lim, 16'h0000});
		lim56      = $signed({25'd0, cfg.max_out, 16'h0000});
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sp_q <= item.setpoint;
			fb_q <= item.feedback;
		end
		if (cmd.err) begin
			e_q      <= err_n;
			int_en_q <= sep_ok && !blocked;
		end
		prod_s1 <= mul_a * mul_b;
		acc_q   <= acc_d;
		// integral: trapezoid add (when enabled) or delta replace, then symmetric clamp in positional mode
		if (op_s1 == OP_I) begin
			if (cfg.mode == MODE_DELTA) begin
				integ_tmp_q <= prod_x[49:0];
			end else if (int_en_q) begin
				integ_tmp_q <= integ_base + prod_sh1[49:0];
			end else begin
				integ_tmp_q <= integ_base;
			end
		end else if (cmd.clamp_int && cfg.mode == MODE_POS) begin
			if (integ_tmp_q > ilim) begin
				integ_tmp_q <= ilim;
			end else if (integ_tmp_q < -ilim) begin
				integ_tmp_q <= -ilim;
			end
		end
		// filtered derivative: (1-c)*d + c*diff, floor
		case (op_s1)
			OP_DH:   dtmp_q <= prod_x[37:0];
			OP_DC:   dtmp_q <= dtmp_q + prod_x[37:0];
			OP_DL:   dtmp_q <= dtmp_q + prod_sh16[37:0];
			default: dtmp_q <= dtmp_q;
		endcase
		if (cmd.clamp_out) begin
			if (acc_q > lim56) begin
				oacc_tmp_q <= lim56[31:0];
				hit_q      <= 1'b1;
			end else if (acc_q < -lim56) begin
				oacc_tmp_q <= 32'(-lim56);
				hit_q      <= 1'b1;
			end else begin
				oacc_tmp_q <= acc_q[31:0];
				hit_q      <= 1'b0;
			end
		end
	end

	// drive truncated toward zero
	logic signed [15:0] drive_n;
	assign drive_n = oacc_tmp_q[31:16] +
		16'((oacc_tmp_q[31] && (oacc_tmp_q[15:0] != 16'h0000)) ? 1 : 0);

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			res_q <= '0;
		end else if (cmd.commit) begin
			res_q.drive    <= drive_n;
			res_q.at_limit <= hit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1       <= OP_NONE;
			el_q        <= '0;
			ebl_q       <= '0;
			deriv_q     <= '0;
			integ_q     <= '0;
			out_acc_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			op_s1 <= cmd.mul_op;
			if (cmd.clear) begin
				el_q        <= '0;
				ebl_q       <= '0;
				deriv_q     <= '0;
				integ_q     <= '0;
				out_acc_q   <= '0;
				res_valid_q <= 1'b1;
			end else if (cmd.commit) begin
				ebl_q       <= el_q;
				el_q        <= e_q;
				deriv_q     <= dtmp_q[35:0];
				integ_q     <= integ_tmp_q[47:0];
				out_acc_q   <= oacc_tmp_q;
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid     = res_valid_q;
	assign result           = res_q;
	assign status.out_stall = res_valid_q && !result_ready;

	// checks
	logic signed [15:0] lim_pos16, lim_neg16;
	logic               drive_in_lim, drive_on_lim;
	assign lim_pos16    = $signed({1'b0, cfg.max_out});
	assign lim_neg16    = -lim_pos16;
	assign drive_in_lim = (res_q.drive <= lim_pos16) && (res_q.drive >= lim_neg16);
	assign drive_on_lim = (res_q.drive == lim_pos16) || (res_q.drive == lim_neg16);

	`PPDC_ASSERT_IMPL(a_drive_in_range, clk, arst_n, res_valid_q, drive_in_lim)
	`PPDC_ASSERT_IMPL(a_limit_on_edge, clk, arst_n, res_valid_q && res_q.at_limit, drive_on_lim)
	`PPDC_ASSERT_IMPL(a_no_commit_stalled, clk, arst_n, cmd.commit || cmd.clear, !status.out_stall)

endmodule

FILE: rtl/pid_position_delta_controller_core.sv
// PID controller core (positional and incremental), top level.
// Usage:
//   item channel (item_valid/item_ready/item): one beat carries cmd, setpoint and
//   feedback. cmd clear zeroes the controller state; cmd step runs one control step.
//   result channel (result_valid/result_ready/result): one beat per item with the
//   saturated drive value and the at_limit flag.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes, always
//   ready; write only while no item is in flight.
// Sequence:
//   a step item is taken when the core is idle; its result is registered in the
//   commit state, and a new item is taken only once the core is back in idle.
//   A step walks an error/deadband stage, eight issues on the one shared
//   32x20 multiplier, a wait for the last product, a clamp and a commit.
//   A clear item passes through a single clear state instead.
// Reset: arst_n clears gains, mode and deadband to zero, both limits to 16384 and
//   all controller state to zero; no result is pending after reset.
// Stall: a finished result waits in the output register. The next item is still
//   taken; the core holds at the end of that item until the waiting beat is taken.
// Depends on ppdc_pkg, ppdc_ctrl and ppdc_datapath.
module pid_position_delta_controller_core import ppdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t       cfg_q;
	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	// config writes never stall
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= MODE_POS;
			cfg_q.kp       <= '0;
			cfg_q.ki       <= '0;
			cfg_q.kd       <= '0;
			cfg_q.kf       <= '0;
			cfg_q.max_out  <= 15'd16384;
			cfg_q.int_lim  <= 15'd16384;
			cfg_q.deadband <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MODE:     cfg_q.mode     <= cfg_data[0];
				REG_KP:       cfg_q.kp       <= cfg_data;
				REG_KI:       cfg_q.ki       <= cfg_data;
				REG_KD:       cfg_q.kd       <= cfg_data;
				REG_KF:       cfg_q.kf       <= cfg_data;
				REG_MAX_OUT:  cfg_q.max_out  <= cfg_data[14:0];
				REG_INT_LIM:  cfg_q.int_lim  <= cfg_data[14:0];
				REG_DEADBAND: cfg_q.deadband <= cfg_data[14:0];
				default:      cfg_q.mode     <= cfg_q.mode;
			endcase
		end
	end

	// sequencer: one step walks error, eight products, wait, clamp, commit
	ppdc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_cmd   (item.cmd),
		.item_ready (item_ready),
		.cmd        (dp_cmd),
		.status     (dp_status)
	);

	// arithmetic, controller state and the result register
	ppdc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item         (item),
		.cmd          (dp_cmd),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result),
		.status       (dp_status)
	);

endmodule
